/* sv/ostt_pkg.sv */
// ostt_pkg: shared types and constants for the one-shot timer table.
// Used by ostt_entry_ram and one_shot_timer_table; depends on nothing.
`default_nettype none

package ostt_pkg;

  localparam int unsigned SLOTS_DEFAULT = 16;
  localparam int unsigned MAX_FIRES     = 16;

  localparam int unsigned IN_W  = 216;
  localparam int unsigned OUT_W = 112;

  localparam logic [20:0] USEC_ONE_SEC   = 21'd1000000;
  localparam logic [20:0] USEC_TWO_SEC   = 21'd2000000;
  localparam logic [19:0] MIN_DELAY_USEC = 20'd500000;

  typedef enum logic [1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_UNREGISTER = 2'd1,
    CMD_POLL       = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_REJECT   = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_BAD_SLOT = 2'd3
  } status_t;

  localparam logic [1:0] KIND_TASK  = 2'd0;
  localparam logic [1:0] KIND_INNER = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] deadline_sec;
    logic [19:0] deadline_usec;
    logic [1:0]  kind;
    logic [31:0] first_arg;
    logic [31:0] second_arg;
    logic [7:0]  handler;
  } entry_t;

endpackage

`default_nettype wire

/* sv/ostt_entry_ram.sv */
// ostt_entry_ram: timer entry store, one write and one registered read port.
// Depends on ostt_pkg for the entry layout.
`default_nettype none

module ostt_entry_ram import ostt_pkg::*; #(
  parameter int unsigned DEPTH = SLOTS_DEFAULT,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* sv/one_shot_timer_table.sv */
// one_shot_timer_table: table of one-shot timers with register, unregister,
// poll and offset-clear commands. Depends on ostt_pkg and ostt_entry_ram.
//
// One command word is taken at a time. Poll, and register unless rejected, run a
// scan that reads one slot per cycle, when not held, through the single read port
// of the entry memory; every fired timer word holds the scan while the output
// register is still full. Unregister and clear skip the scan. A new command is
// accepted as soon as the previous final word is in the output register. Poll
// applies the server offset to live deadlines once until a clear command, and
// reports at most 16 fired timers per poll, in slot order, followed by a closing
// word with tlast.
`default_nettype none

module one_shot_timer_table import ostt_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // now_sec, now_usec, server_offset, delay_sec, delay_usec, kind,
  // first_arg, second_arg, handler, slot, 2 bits zero fill
  input  wire logic [IN_W-1:0]  s_tdata,
  // cmd
  input  wire logic [1:0]       s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // status, entry_slot, fire_first_arg, fire_second_arg, fire_handler,
  // deadline_sec, 2 bits zero fill
  output logic [OUT_W-1:0]      m_tdata,
  // fired
  output logic [0:0]            m_tuser,
  output logic                  m_tlast
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned FW = $clog2(MAX_FIRES + 1);

  // input word fields
  logic [31:0] in_now_sec;
  logic [19:0] in_now_usec;
  logic [31:0] in_server_offset;
  logic [31:0] in_delay_sec;
  logic [19:0] in_delay_usec;
  logic [1:0]  in_kind;
  logic [31:0] in_first_arg;
  logic [31:0] in_second_arg;
  logic [7:0]  in_handler;
  logic [3:0]  in_slot;
  cmd_t        in_cmd;

  assign in_now_sec       = s_tdata[31:0];
  assign in_now_usec      = s_tdata[51:32];
  assign in_server_offset = s_tdata[83:52];
  assign in_delay_sec     = s_tdata[115:84];
  assign in_delay_usec    = s_tdata[135:116];
  assign in_kind          = s_tdata[137:136];
  assign in_first_arg     = s_tdata[169:138];
  assign in_second_arg    = s_tdata[201:170];
  assign in_handler       = s_tdata[209:202];
  assign in_slot          = s_tdata[213:210];
  assign in_cmd           = cmd_t'(s_tuser);

  function automatic logic [3:0] slot4(input logic [IW-1:0] idx);
    logic [IW+3:0] w;
    w = (IW+4)'(idx);
    return w[3:0];
  endfunction

  state_t state;
  state_t state_next;

  // held command
  cmd_t        cmd;
  logic [19:0] now_usec;
  logic [31:0] offset;
  logic [31:0] delay_sec;
  logic [19:0] delay_usec;
  logic [1:0]  kind;
  logic [31:0] first_arg;
  logic [31:0] second_arg;
  logic [7:0]  handler;
  logic [3:0]  slot;
  logic [31:0] srv_now;
  logic [19:0] usec_sum;
  logic [1:0]  usec_carry;
  logic [31:0] dl_sec;
  logic [19:0] dl_usec;
  logic        reject;
  logic        apply;
  logic        offset_applied;

  logic [SLOTS-1:0] valid;

  // scan
  logic [CW-1:0] iss;
  logic          p_valid;
  logic [IW-1:0] p_idx;
  logic [FW-1:0] fire_cnt;
  logic          dup_found;
  logic [IW-1:0] dup_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;

  // output register
  logic        out_valid;
  status_t     out_status;
  logic [3:0]  out_slot;
  logic        out_fired;
  logic [31:0] out_first_arg;
  logic [31:0] out_second_arg;
  logic [7:0]  out_handler;
  logic [31:0] out_dl_sec;
  logic        out_last;

  // memory port
  entry_t        rd_data;
  entry_t        wr_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic          rd_en;

  logic          accept;
  logic [20:0]   usec_raw;
  logic [20:0]   usec_red;
  logic [1:0]    usec_c;
  logic          reject_c;
  logic [31:0]   dl_adj;
  logic          expired;
  logic          is_dup;
  logic          poll_fire;
  logic          out_free;
  logic          scan_stall;
  logic          scan_adv;
  logic          issue;
  logic          scan_end;
  logic          write_back;
  logic          reg_store;
  logic          done_go;
  logic [CW+3:0] slot_ext;
  logic          slot_bad;
  logic [IW-1:0] slot_idx;
  status_t       fin_status;
  logic [3:0]    fin_slot;

  ostt_entry_ram #(
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (iss[IW-1:0]),
    .rd_data (rd_data)
  );

  // microsecond sum, carrying up to two seconds
  always_comb begin
    usec_raw = 21'(in_now_usec) + 21'(in_delay_usec);
    if (usec_raw >= USEC_TWO_SEC) begin
      usec_red = usec_raw - USEC_TWO_SEC;
      usec_c   = 2'd2;
    end else if (usec_raw >= USEC_ONE_SEC) begin
      usec_red = usec_raw - USEC_ONE_SEC;
      usec_c   = 2'd1;
    end else begin
      usec_red = usec_raw;
      usec_c   = 2'd0;
    end
  end

  assign reject_c = delay_sec[31] || (delay_sec == 32'd0 && delay_usec < MIN_DELAY_USEC) ||
                    handler == 8'd0 || kind >= KIND_INNER;

  assign dl_adj  = rd_data.deadline_sec + (apply ? offset : 32'd0);
  assign expired = valid[p_idx] && fire_cnt < FW'(MAX_FIRES) &&
                   (srv_now > dl_adj ||
                    (srv_now == dl_adj && now_usec >= rd_data.deadline_usec));
  assign is_dup  = valid[p_idx] && rd_data.handler == handler &&
                   rd_data.first_arg == first_arg && rd_data.second_arg == second_arg &&
                   rd_data.kind == kind &&
                   (kind == KIND_TASK || rd_data.deadline_sec == dl_sec);

  assign slot_ext = (CW+4)'(slot);
  assign slot_bad = slot_ext >= (CW+4)'(SLOTS);
  assign slot_idx = slot_ext[IW-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (in_cmd)
            CMD_REGISTER: state_next = ST_CALC;
            CMD_POLL:     state_next = ST_SCAN;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_CALC: state_next = reject_c ? ST_DONE : ST_SCAN;
      ST_SCAN: if (scan_end) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready   = (state == ST_IDLE);
    accept     = s_tvalid && s_tready;
    out_free   = !out_valid || m_tready;
    poll_fire  = (state == ST_SCAN) && p_valid && cmd == CMD_POLL && expired;
    scan_stall = poll_fire && !out_free;
    scan_adv   = (state == ST_SCAN) && !scan_stall;
    issue      = scan_adv && iss < CW'(SLOTS);
    rd_en      = issue;
    scan_end   = scan_adv && iss == CW'(SLOTS) && !p_valid;
    write_back = scan_adv && p_valid && cmd == CMD_POLL && apply && valid[p_idx] && !expired;
    done_go    = (state == ST_DONE) && out_free;
    reg_store  = done_go && cmd == CMD_REGISTER && !reject && !dup_found && free_found;

    wr_en   = write_back || reg_store;
    wr_addr = reg_store ? free_idx : p_idx;
    if (reg_store) begin
      wr_data.deadline_sec  = dl_sec;
      wr_data.deadline_usec = dl_usec;
      wr_data.kind          = kind;
      wr_data.first_arg     = first_arg;
      wr_data.second_arg    = second_arg;
      wr_data.handler       = handler;
    end else begin
      wr_data              = rd_data;
      wr_data.deadline_sec = dl_adj;
    end

    fin_status = STAT_OK;
    fin_slot   = 4'd0;
    case (cmd)
      CMD_REGISTER: begin
        if (reject) begin
          fin_status = STAT_REJECT;
        end else if (dup_found) begin
          fin_slot = slot4(dup_idx);
        end else if (free_found) begin
          fin_slot = slot4(free_idx);
        end else begin
          fin_status = STAT_FULL;
        end
      end
      CMD_UNREGISTER: begin
        fin_status = slot_bad ? STAT_BAD_SLOT : STAT_OK;
        fin_slot   = slot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command hold
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= in_cmd;
      now_usec   <= in_now_usec;
      offset     <= in_server_offset;
      delay_sec  <= in_delay_sec;
      delay_usec <= in_delay_usec;
      kind       <= in_kind;
      first_arg  <= in_first_arg;
      second_arg <= in_second_arg;
      handler    <= in_handler;
      slot       <= in_slot;
      srv_now    <= in_now_sec + in_server_offset;
      usec_sum   <= usec_red[19:0];
      usec_carry <= usec_c;
    end
    if (state == ST_CALC) begin
      dl_sec  <= srv_now + delay_sec + 32'(usec_carry);
      dl_usec <= usec_sum;
      reject  <= reject_c;
    end
  end

  // offset flag
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_applied <= 1'b0;
      apply          <= 1'b0;
    end else begin
      if (accept && in_cmd == CMD_POLL) begin
        apply <= !offset_applied && in_server_offset != 32'd0;
        if (in_server_offset != 32'd0) begin
          offset_applied <= 1'b1;
        end
      end
      if (done_go && cmd == CMD_CLEAR) begin
        offset_applied <= 1'b0;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (scan_adv && p_valid && cmd == CMD_POLL && expired) begin
        valid[p_idx] <= 1'b0;
      end
      if (reg_store) begin
        valid[free_idx] <= 1'b1;
      end
      if (done_go && cmd == CMD_UNREGISTER && !slot_bad) begin
        valid[slot_idx] <= 1'b0;
      end
    end
  end

  // scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      iss        <= '0;
      p_valid    <= 1'b0;
      p_idx      <= '0;
      fire_cnt   <= '0;
      dup_found  <= 1'b0;
      dup_idx    <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
    end else if (state != ST_SCAN) begin
      if (state != ST_DONE) begin
        iss        <= '0;
        p_valid    <= 1'b0;
        fire_cnt   <= '0;
        dup_found  <= 1'b0;
        free_found <= 1'b0;
      end
    end else if (scan_adv) begin
      p_valid <= issue;
      if (issue) begin
        p_idx <= iss[IW-1:0];
        iss   <= iss + CW'(1);
      end
      if (p_valid) begin
        if (cmd == CMD_POLL && expired) begin
          fire_cnt <= fire_cnt + FW'(1);
        end
        if (cmd == CMD_REGISTER) begin
          if (is_dup && !dup_found) begin
            dup_found <= 1'b1;
            dup_idx   <= p_idx;
          end
          if (!valid[p_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= p_idx;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((poll_fire && out_free) || done_go) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_fire && out_free) begin
      out_status     <= STAT_OK;
      out_slot       <= slot4(p_idx);
      out_fired      <= 1'b1;
      out_first_arg  <= rd_data.first_arg;
      out_second_arg <= rd_data.second_arg;
      out_handler    <= rd_data.handler;
      out_dl_sec     <= dl_adj;
      out_last       <= 1'b0;
    end else if (done_go) begin
      out_status     <= fin_status;
      out_slot       <= fin_slot;
      out_fired      <= 1'b0;
      out_first_arg  <= 32'd0;
      out_second_arg <= 32'd0;
      out_handler    <= 8'd0;
      out_dl_sec     <= 32'd0;
      out_last       <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_dl_sec, out_handler, out_second_arg, out_first_arg,
                     out_slot, out_status};
  assign m_tuser  = out_fired;
  assign m_tlast  = out_last;

endmodule

`default_nettype wire
